@@ src/uart_frame_receiver_assert.svh @@
// assertion macros for the uart frame receiver checks
`ifndef UART_FRAME_RECEIVER_ASSERT_SVH
`define UART_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define UFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uart frame receiver check failed");

// next-cycle implication, sampled on clk, off during rst
`define UFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uart frame receiver check failed");

`endif

@@ src/ufr_pkg.sv @@
// shared types and constants for the uart frame receiver
`timescale 1ns / 1ps

package ufr_pkg;

  localparam int HalfBitW = 16;
  localparam int TickW    = HalfBitW + 1;
  localparam int BitIdxW  = 4;
  localparam int ByteW    = 8;
  localparam int StatusW  = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [StatusW-1:0] STATUS_OK      = 2'd0;
  localparam logic [StatusW-1:0] STATUS_FRAMING = 2'd1;
  localparam logic [StatusW-1:0] STATUS_PARITY  = 2'd2;

  localparam logic [1:0] PAR_NONE = 2'd0;
  localparam logic [1:0] PAR_EVEN = 2'd1;
  localparam logic [1:0] PAR_ODD  = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_HALF_BIT    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DATA_BITS   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_STOP_BITS   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_PARITY_MODE = 2'd3;

  localparam logic [HalfBitW-1:0] RST_HALF_BIT    = 16'd1093;
  localparam logic [BitIdxW-1:0]  RST_DATA_BITS   = 4'd8;
  localparam logic [1:0]          RST_STOP_BITS   = 2'd1;
  localparam logic [1:0]          RST_PARITY_MODE = PAR_NONE;

  typedef struct packed {
    logic [HalfBitW-1:0] half_bit_ticks;
    logic [BitIdxW-1:0]  data_bits;
    logic [1:0]          stop_bits;
    logic [1:0]          parity_mode;
  } ufr_cfg_t;

  typedef struct packed {
    logic               emit;
    logic [ByteW-1:0]   data;
    logic [StatusW-1:0] status;
  } ufr_result_t;

endpackage

@@ src/ufr_rx_fsm.sv @@
// receive sequencer: frame state, tick counter, bit assembly and checks
`timescale 1ns / 1ps

module ufr_rx_fsm import ufr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic        rx_level,
  input  ufr_cfg_t    cfg,
  output ufr_result_t res
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_DATA,
    PH_PARITY,
    PH_STOP
  } phase_t;

  phase_t              phase, phase_next;
  logic [TickW-1:0]    tick_count, tick_count_next;
  logic [BitIdxW-1:0]  bit_index, bit_index_next;
  logic [ByteW-1:0]    shift_data, shift_data_next;
  logic                sampled_parity, sampled_parity_next;

  logic [TickW-1:0]    half_wait;
  logic [TickW-1:0]    full_wait;
  logic                parity_on;
  logic [BitIdxW-1:0]  bit_inc;
  logic                go_after;
  phase_t              after_from;
  logic                go_complete;
  logic                calc_par;

  assign half_wait = (cfg.half_bit_ticks == '0) ? TickW'(1) : {1'b0, cfg.half_bit_ticks};
  assign full_wait = (cfg.half_bit_ticks == '0) ? TickW'(1) : {cfg.half_bit_ticks, 1'b0};
  assign parity_on = (cfg.parity_mode == PAR_EVEN) || (cfg.parity_mode == PAR_ODD);
  assign bit_inc   = bit_index + BitIdxW'(1);

  always_comb begin
    phase_next          = phase;
    tick_count_next     = tick_count;
    bit_index_next      = bit_index;
    shift_data_next     = shift_data;
    sampled_parity_next = sampled_parity;
    res                 = '0;
    go_after            = 1'b0;
    after_from          = PH_START;
    go_complete         = 1'b0;
    calc_par            = 1'b0;

    if (phase == PH_IDLE) begin
      if (!rx_level) begin
        phase_next          = PH_START;
        tick_count_next     = half_wait;
        bit_index_next      = '0;
        shift_data_next     = '0;
        sampled_parity_next = 1'b0;
      end
    end else if (tick_count > TickW'(1)) begin
      tick_count_next = tick_count - TickW'(1);
    end else begin
      case (phase)
        PH_START: begin
          if (rx_level) begin
            res.emit        = 1'b1;
            res.status      = STATUS_FRAMING;
            phase_next      = PH_IDLE;
            tick_count_next = '0;
            bit_index_next  = '0;
          end else begin
            go_after   = 1'b1;
            after_from = PH_START;
          end
        end
        PH_DATA: begin
          if (!bit_index[BitIdxW-1]) begin
            shift_data_next[bit_index[2:0]] = shift_data[bit_index[2:0]] | rx_level;
          end
          if (bit_inc < cfg.data_bits) begin
            bit_index_next  = bit_inc;
            tick_count_next = full_wait;
          end else begin
            go_after   = 1'b1;
            after_from = PH_DATA;
          end
        end
        PH_PARITY: begin
          sampled_parity_next = rx_level;
          go_after            = 1'b1;
          after_from          = PH_PARITY;
        end
        PH_STOP: begin
          if (!rx_level) begin
            res.emit        = 1'b1;
            res.status      = STATUS_FRAMING;
            phase_next      = PH_IDLE;
            tick_count_next = '0;
            bit_index_next  = '0;
          end else if (bit_inc < {2'b00, cfg.stop_bits}) begin
            bit_index_next  = bit_inc;
            tick_count_next = full_wait;
          end else begin
            go_complete = 1'b1;
          end
        end
        default: begin
          phase_next      = PH_IDLE;
          tick_count_next = '0;
          bit_index_next  = '0;
        end
      endcase
    end

    if (go_after) begin
      bit_index_next  = '0;
      tick_count_next = full_wait;
      if (after_from == PH_START && cfg.data_bits != '0) begin
        phase_next = PH_DATA;
      end else if (after_from != PH_PARITY && parity_on) begin
        phase_next = PH_PARITY;
      end else if (cfg.stop_bits != '0) begin
        phase_next = PH_STOP;
      end else begin
        go_complete = 1'b1;
      end
    end

    if (go_complete) begin
      calc_par        = (^shift_data_next) ^ (cfg.parity_mode == PAR_ODD);
      res.emit        = 1'b1;
      phase_next      = PH_IDLE;
      tick_count_next = '0;
      bit_index_next  = '0;
      if (parity_on && (calc_par != sampled_parity_next)) begin
        res.status = STATUS_PARITY;
      end else begin
        res.data   = shift_data_next;
        res.status = STATUS_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      tick_count     <= '0;
      bit_index      <= '0;
      shift_data     <= '0;
      sampled_parity <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      tick_count     <= tick_count_next;
      bit_index      <= bit_index_next;
      shift_data     <= shift_data_next;
      sampled_parity <= sampled_parity_next;
    end
  end

endmodule

@@ src/uart_frame_receiver.sv @@
// uart frame receiver top level: config registers, sequencer and result register
// latency: a result word is valid the cycle after the input word with the last sample
// throughput: one line sample word per cycle; stalls only while a result waits unread
// config registers take effect on the cycle after the write
// rst (synchronous, active high) clears the frame state and the result valid flag, and
// restores the config registers to their defaults
`timescale 1ns / 1ps

module uart_frame_receiver import ufr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                rx_level,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ByteW-1:0]    received_byte,
  output logic [StatusW-1:0]  frame_status,
  input  logic                cfg_write_en,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  ufr_cfg_t    cfg;
  ufr_result_t res;
  logic        step;

  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_bit_ticks <= RST_HALF_BIT;
      cfg.data_bits      <= RST_DATA_BITS;
      cfg.stop_bits      <= RST_STOP_BITS;
      cfg.parity_mode    <= RST_PARITY_MODE;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_HALF_BIT:    cfg.half_bit_ticks <= cfg_data;
        REG_DATA_BITS:   cfg.data_bits      <= cfg_data[BitIdxW-1:0];
        REG_STOP_BITS:   cfg.stop_bits      <= cfg_data[1:0];
        REG_PARITY_MODE: cfg.parity_mode    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  ufr_rx_fsm u_rx_fsm (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .rx_level (rx_level),
    .cfg      (cfg),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && res.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.emit) begin
      received_byte <= res.data;
      frame_status  <= res.status;
    end
  end

endmodule

@@ src/ufr_checker.sv @@
// port-level checks for the uart frame receiver, bound to the top level
`timescale 1ns / 1ps
`include "uart_frame_receiver_assert.svh"

module ufr_checker import ufr_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [ByteW-1:0]    received_byte,
  input logic [StatusW-1:0]  frame_status
);

  `UFR_ASSERT_NOW(a_status_legal, out_valid, frame_status != 2'd3)
  `UFR_ASSERT_NOW(a_error_byte_zero, out_valid && frame_status != STATUS_OK, received_byte == '0)
  `UFR_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)
  `UFR_ASSERT_NEXT(a_result_from_word, !out_valid, !out_valid || $past(in_valid && in_ready))
  `UFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(received_byte) && $stable(frame_status))

endmodule

bind uart_frame_receiver ufr_checker u_checker (.*);

@@ bench/tb.sv @@
// testbench for uart_frame_receiver: line-sample words against a frame predictor
`timescale 1ns / 1ps

module tb;
  import ufr_pkg::*;

  typedef enum logic [2:0] {
    RX_IDLE, RX_START, RX_DATA, RX_PARBIT, RX_STOP
  } rx_phase_t;

  typedef enum int {
    FLAW_NONE, FLAW_PARITY, FLAW_STOP, FLAW_GLITCH, FLAW_NOISE
  } frame_flaw_t;

  typedef struct packed {
    logic [ByteW-1:0]   data;
    logic [StatusW-1:0] status;
  } frame_result_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                rx_level = 1'b1;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ByteW-1:0]    received_byte;
  logic [StatusW-1:0]  frame_status;
  logic                cfg_write_en = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = REG_HALF_BIT;
  logic [CfgDataW-1:0] cfg_data = '0;

  uart_frame_receiver dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_level(rx_level),
    .out_valid(out_valid), .out_ready(out_ready),
    .received_byte(received_byte), .frame_status(frame_status),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of the config registers and frame state
  logic [HalfBitW-1:0] cfg_half = RST_HALF_BIT;
  logic [BitIdxW-1:0]  cfg_dbits = RST_DATA_BITS;
  logic [1:0]          cfg_sbits = RST_STOP_BITS;
  logic [1:0]          cfg_pmode = RST_PARITY_MODE;

  rx_phase_t           rx_phase = RX_IDLE;
  logic [TickW-1:0]    ticks_left = '0;
  logic [BitIdxW-1:0]  bit_idx = '0;
  logic [ByteW-1:0]    shift_byte = '0;
  logic                parity_seen = 1'b0;

  frame_result_t       expected_frames[$];
  frame_result_t       oldest;
  int unsigned         words_sent = 0;
  int unsigned         frames_predicted = 0;
  int unsigned         mismatches = 0;
  bit                  idle_on = 1'b1;
  bit                  stall_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(30_000_000);
    $display("uart_frame_receiver verification failed");
    $finish;
  end

  function automatic logic [TickW-1:0] half_wait();
    return (cfg_half == 0) ? TickW'(1) : TickW'(cfg_half);
  endfunction

  function automatic logic [TickW-1:0] full_wait();
    logic [TickW-1:0] w;
    w = {cfg_half, 1'b0};
    return (w == 0) ? TickW'(1) : w;
  endfunction

  function automatic bit parity_enabled();
    return cfg_pmode == PAR_EVEN || cfg_pmode == PAR_ODD;
  endfunction

  function automatic void post_frame(input logic [ByteW-1:0] data,
                                     input logic [StatusW-1:0] status);
    frame_result_t r;
    r.data = data;
    r.status = status;
    expected_frames.push_back(r);
    frames_predicted++;
    rx_phase = RX_IDLE;
    ticks_left = '0;
    bit_idx = '0;
  endfunction

  function automatic void close_frame();
    logic p;
    if (parity_enabled()) begin
      p = ^shift_byte;
      if (cfg_pmode == PAR_ODD) p = ~p;
      if (p != parity_seen) begin
        post_frame('0, STATUS_PARITY);
        return;
      end
    end
    post_frame(shift_byte, STATUS_OK);
  endfunction

  function automatic void next_phase(input rx_phase_t from);
    bit_idx = '0;
    ticks_left = full_wait();
    if (from == RX_START && cfg_dbits > 0) rx_phase = RX_DATA;
    else if (from <= RX_DATA && parity_enabled()) rx_phase = RX_PARBIT;
    else if (from <= RX_PARBIT && cfg_sbits > 0) rx_phase = RX_STOP;
    else close_frame();
  endfunction

  function automatic void predict_sample(input logic lvl);
    if (rx_phase == RX_IDLE) begin
      if (!lvl) begin
        rx_phase = RX_START;
        ticks_left = half_wait();
        bit_idx = '0;
        shift_byte = '0;
        parity_seen = 1'b0;
      end
      return;
    end
    if (ticks_left > 1) begin
      ticks_left--;
      return;
    end
    case (rx_phase)
      RX_START: begin
        if (lvl) post_frame('0, STATUS_FRAMING);
        else next_phase(RX_START);
      end
      RX_DATA: begin
        if (bit_idx < 8) shift_byte[bit_idx[2:0]] = shift_byte[bit_idx[2:0]] | lvl;
        bit_idx = bit_idx + 1'b1;
        if (bit_idx < cfg_dbits) ticks_left = full_wait();
        else next_phase(RX_DATA);
      end
      RX_PARBIT: begin
        parity_seen = lvl;
        next_phase(RX_PARBIT);
      end
      RX_STOP: begin
        if (!lvl) begin
          post_frame('0, STATUS_FRAMING);
        end else begin
          bit_idx = bit_idx + 1'b1;
          if (bit_idx < BitIdxW'(cfg_sbits)) ticks_left = full_wait();
          else close_frame();
        end
      end
      default: begin
        rx_phase = RX_IDLE;
        ticks_left = '0;
        bit_idx = '0;
      end
    endcase
  endfunction

  // ready is settled by the falling edge, so it is sampled there
  task automatic send_sample(input logic lvl);
    logic took;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_level <= lvl;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    words_sent++;
    predict_sample(lvl);
  endtask

  // finish any frame in flight, then let the block go quiet
  task automatic settle();
    while (rx_phase != RX_IDLE) send_sample(1'b1);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_cfg(input logic [HalfBitW-1:0] half, input logic [BitIdxW-1:0] dbits,
                           input logic [1:0] sbits, input logic [1:0] pmode);
    logic [CfgDataW-1:0] junk;
    settle();
    junk = CfgDataW'($urandom);
    cfg_write_en <= 1'b1;
    cfg_index <= REG_HALF_BIT;
    cfg_data <= half;
    @(posedge clk);
    cfg_index <= REG_DATA_BITS;
    cfg_data <= {junk[15:4], dbits};
    @(posedge clk);
    cfg_index <= REG_STOP_BITS;
    cfg_data <= {junk[13:0], sbits};
    @(posedge clk);
    cfg_index <= REG_PARITY_MODE;
    cfg_data <= {junk[7:0], junk[15:10], pmode};
    @(posedge clk);
    cfg_write_en <= 1'b0;
    cfg_half = half;
    cfg_dbits = dbits;
    cfg_sbits = sbits;
    cfg_pmode = pmode;
    @(posedge clk);
  endtask

  task automatic send_frame(input logic [15:0] payload, input frame_flaw_t flaw);
    int unsigned bit_len, start_len, k, j, stop_hit;
    logic par;
    bit_len = (cfg_half == 0) ? 1 : 2 * cfg_half;
    start_len = (cfg_half == 0) ? 2 : bit_len;
    repeat ($urandom_range(0, 3)) send_sample(1'b1);
    case (flaw)
      FLAW_GLITCH: begin
        repeat ($urandom_range(1, half_wait())) send_sample(1'b0);
      end
      FLAW_NOISE: begin
        repeat ($urandom_range(1, 40)) send_sample(1'($urandom));
      end
      default: begin
        repeat (start_len) send_sample(1'b0);
        par = 1'b0;
        for (k = 0; k < cfg_dbits; k++) begin
          if (k < 8) par ^= payload[k];
          repeat (bit_len) send_sample(payload[k]);
        end
        if (parity_enabled()) begin
          if (cfg_pmode == PAR_ODD) par = ~par;
          if (flaw == FLAW_PARITY) par = ~par;
          repeat (bit_len) send_sample(par);
        end
        stop_hit = (flaw == FLAW_STOP && cfg_sbits > 0) ? $urandom_range(0, cfg_sbits - 1) : 99;
        for (j = 0; j < cfg_sbits; j++) begin
          repeat (bit_len) send_sample(j != stop_hit);
        end
      end
    endcase
    while (rx_phase != RX_IDLE) send_sample(1'b1);
    repeat ($urandom_range(0, 3)) send_sample(1'b1);
  endtask

  function automatic frame_flaw_t pick_flaw();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 13) return FLAW_NONE;
    if (r < 15) return FLAW_PARITY;
    if (r < 17) return FLAW_STOP;
    if (r < 18) return FLAW_GLITCH;
    return FLAW_NOISE;
  endfunction

  task automatic random_cfg();
    int unsigned r;
    logic [HalfBitW-1:0] half;
    logic [BitIdxW-1:0] dbits;
    logic [1:0] sbits;
    r = $urandom_range(0, 19);
    if (r < 12) half = HalfBitW'($urandom_range(0, 3));
    else if (r < 18) half = HalfBitW'($urandom_range(4, 12));
    else half = HalfBitW'($urandom_range(13, 40));
    dbits = $urandom_range(0, 1) ? BitIdxW'($urandom_range(5, 8))
                                 : BitIdxW'($urandom_range(0, 15));
    r = $urandom_range(0, 9);
    sbits = (r == 0) ? 2'd0 : (r < 6) ? 2'd1 : (r < 9) ? 2'd2 : 2'd3;
    apply_cfg(half, dbits, sbits, 2'($urandom_range(0, 3)));
  endtask

  // only the half period moves off its reset value
  task automatic test_reset_defaults();
    cfg_write_en <= 1'b1;
    cfg_index <= REG_HALF_BIT;
    cfg_data <= 16'd1;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    cfg_half = 16'd1;
    @(posedge clk);
    send_frame(16'h00A5, FLAW_NONE);
    send_frame(16'h0000, FLAW_GLITCH);
  endtask

  task automatic test_parity_and_stop();
    apply_cfg(16'd0, 4'd8, 2'd1, PAR_EVEN);
    send_frame(16'h0000, FLAW_NONE);
    send_frame(16'h00FF, FLAW_NONE);
    send_frame(16'h005A, FLAW_PARITY);
    send_frame(16'h003C, FLAW_STOP);
    send_frame(16'h0000, FLAW_GLITCH);
    apply_cfg(16'd0, 4'd8, 2'd2, PAR_ODD);
    send_frame(16'h0001, FLAW_NONE);
    send_frame(16'h0080, FLAW_PARITY);
    send_frame(16'h00FF, FLAW_STOP);
  endtask

  task automatic test_frame_widths();
    apply_cfg(16'd1, 4'd0, 2'd1, PAR_NONE);
    send_frame(16'h00FF, FLAW_NONE);
    apply_cfg(16'd1, 4'd15, 2'd1, PAR_EVEN);
    send_frame(16'hFFFF, FLAW_NONE);
    send_frame(16'h7E81, FLAW_PARITY);
    apply_cfg(16'd1, 4'd8, 2'd0, PAR_ODD);
    send_frame(16'h00C3, FLAW_NONE);
    apply_cfg(16'd1, 4'd8, 2'd3, PAR_NONE);
    send_frame(16'h0096, FLAW_NONE);
    send_frame(16'h0069, FLAW_STOP);
    apply_cfg(16'd1, 4'd5, 2'd1, 2'd3);
    send_frame(16'h0015, FLAW_NONE);
    apply_cfg(16'd1, 4'd0, 2'd0, PAR_NONE);
    send_frame(16'h0000, FLAW_NONE);
    apply_cfg(16'd2, 4'd1, 2'd2, PAR_EVEN);
    send_frame(16'h0001, FLAW_NONE);
  endtask

  // long half period; frame ends at the start sample
  task automatic test_long_period();
    apply_cfg(16'd64, 4'd0, 2'd0, PAR_NONE);
    repeat (65) send_sample(1'b0);
    send_frame(16'h0000, FLAW_GLITCH);
  endtask

  task automatic test_random_frames(input int unsigned word_goal,
                                    input int unsigned frame_goal);
    int unsigned words0, frames0;
    words0 = words_sent;
    frames0 = frames_predicted;
    while (words_sent - words0 < word_goal || frames_predicted - frames0 < frame_goal) begin
      random_cfg();
      repeat ($urandom_range(2, 4)) send_frame(16'($urandom), pick_flaw());
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (stall_on && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual byte %h status %0d",
                 $time, received_byte, frame_status);
        mismatches++;
      end else begin
        oldest = expected_frames.pop_front();
        if (received_byte !== oldest.data) begin
          $display("%0t: received_byte mismatch: expected %h, actual %h",
                   $time, oldest.data, received_byte);
          mismatches++;
        end
        if (frame_status !== oldest.status) begin
          $display("%0t: frame_status mismatch: expected %0d, actual %0d",
                   $time, oldest.status, frame_status);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_parity_and_stop();
    test_frame_widths();
    test_long_period();
    test_random_frames(700, 6);
    settle();
    idle_on = 1'b0;
    stall_on = 1'b0;
    test_random_frames(200, 3);
    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("uart_frame_receiver verification clean");
    end else begin
      $display("uart_frame_receiver verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/ufr_pkg.sv
src/ufr_rx_fsm.sv
src/uart_frame_receiver.sv
src/ufr_checker.sv
bench/tb.sv
